### hdl/pressure_temperature_compensation_core_macros.svh
// Assertion macros used by the checker file.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_CORE_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_CORE_MACROS_SVH

// Checked only outside reset; expects clk and rst_n in scope.
`define PTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ptc_pkg.sv
// Shared constants for the pressure and temperature compensation core.
package ptc_pkg;

  localparam int RAW_W       = 20;
  localparam int OUT_W       = 32;
  localparam int CAL_W       = 32;
  localparam int NUM_CAL_REGS = 6;
  localparam int CAL_IDX_W   = $clog2(NUM_CAL_REGS);
  localparam int WORD_W      = 64;
  localparam int HALF_W      = WORD_W / 2;
  localparam int MUL_LAT     = 2;
  localparam int DIV_LAT     = WORD_W + 2;

  localparam logic [CAL_IDX_W-1:0] REG_T1_T2 = CAL_IDX_W'(0);
  localparam logic [CAL_IDX_W-1:0] REG_T3_P1 = CAL_IDX_W'(1);
  localparam logic [CAL_IDX_W-1:0] REG_P2_P3 = CAL_IDX_W'(2);
  localparam logic [CAL_IDX_W-1:0] REG_P4_P5 = CAL_IDX_W'(3);
  localparam logic [CAL_IDX_W-1:0] REG_P6_P7 = CAL_IDX_W'(4);
  localparam logic [CAL_IDX_W-1:0] REG_P8_P9 = CAL_IDX_W'(5);

  typedef struct packed {
    logic [OUT_W-1:0] fine;
    logic [OUT_W-1:0] centi;
  } temp_res_t;

endpackage

### hdl/ptc_if.sv
// Channel interfaces: configuration writes, raw samples, compensated results.
interface ptc_cfg_if import ptc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CAL_IDX_W-1:0] index;
  logic [CAL_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface ptc_in_if import ptc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_temperature;
  logic [RAW_W-1:0] raw_pressure;
  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface ptc_out_if import ptc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] fine_temperature;
  logic signed [OUT_W-1:0] temperature_centi;
  logic [OUT_W-1:0]        pressure_q24_8;
  logic                    pressure_invalid;
  modport source (output valid, output fine_temperature, output temperature_centi,
                  output pressure_q24_8, output pressure_invalid, input ready);
  modport sink   (input valid, input fine_temperature, input temperature_centi,
                  input pressure_q24_8, input pressure_invalid, output ready);
endinterface

### hdl/ptc_mul64.sv
// Two-stage 64-bit wrapping multiplier built from 32x32 partial products.
module ptc_mul64 import ptc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] p
);

  logic [WORD_W-1:0] ll_nxt, ll_r, p_r;
  logic [HALF_W-1:0] lh_nxt, hl_nxt, lh_r, hl_r;

  assign ll_nxt = a[HALF_W-1:0] * b[HALF_W-1:0];
  assign lh_nxt = a[HALF_W-1:0] * b[WORD_W-1:HALF_W];
  assign hl_nxt = a[WORD_W-1:HALF_W] * b[HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= ll_nxt;
      lh_r <= lh_nxt;
      hl_r <= hl_nxt;
      p_r  <= ll_r + {lh_r + hl_r, {HALF_W{1'b0}}};
    end
  end

  assign p = p_r;

endmodule

### hdl/ptc_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
module ptc_div import ptc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] num,
  input  logic [WORD_W-1:0] den,
  output logic [WORD_W-1:0] quo
);

  logic [WORD_W-1:0] rem_r [WORD_W+1];
  logic [WORD_W-1:0] quo_r [WORD_W+1];
  logic [WORD_W-1:0] den_r [WORD_W+1];
  logic [WORD_W:0]   neg_r;
  logic [WORD_W-1:0] res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      quo_r[0] <= num[WORD_W-1] ? (~num + 1'b1) : num;
      den_r[0] <= den[WORD_W-1] ? (~den + 1'b1) : den;
      neg_r[0] <= num[WORD_W-1] ^ den[WORD_W-1];
    end
  end

  for (genvar k = 1; k <= WORD_W; k++) begin : g_step
    logic [WORD_W:0] trial;
    logic [WORD_W:0] diff;
    logic            ge;
    assign trial = {rem_r[k-1], quo_r[k-1][WORD_W-1]};
    assign diff  = trial - {1'b0, den_r[k-1]};
    assign ge    = trial >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        quo_r[k] <= {quo_r[k-1][WORD_W-2:0], ge};
        den_r[k] <= den_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= neg_r[WORD_W] ? (~quo_r[WORD_W] + 1'b1) : quo_r[WORD_W];
    end
  end

  assign quo = res_r;

endmodule

### hdl/pressure_temperature_compensation_core.sv
// Top level: pipelined integer temperature and pressure compensation.
// Throughput one item per cycle while the output is not stalled.
// Depth is set mostly by the 64-stage radix-2 divider, plus the pipelined 64-bit multipliers.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits and the calibration registers to 0.
module pressure_temperature_compensation_core import ptc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  ptc_cfg_if.sink  cfg_chan,
  ptc_in_if.sink   in_chan,
  ptc_out_if.source out_chan
);

  localparam int TEMP_STG = 5;
  localparam int LAT      = TEMP_STG + 2 * MUL_LAT + 1 + MUL_LAT + 1 + DIV_LAT
                            + 2 * MUL_LAT + 1;
  localparam int TMP_DLY  = LAT - TEMP_STG;
  localparam int RP_DLY   = 2 * MUL_LAT + 1;
  localparam int INV_DLY  = DIV_LAT + 2 * MUL_LAT + 1;
  localparam int Q_DLY    = 2 * MUL_LAT;

  // calibration registers
  logic [CAL_W-1:0] cal_r [NUM_CAL_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CAL_REGS; i++) cal_r[i] <= '0;
    end else if (cfg_chan.valid && (cfg_chan.index < CAL_IDX_W'(NUM_CAL_REGS))) begin
      cal_r[cfg_chan.index] <= cfg_chan.data;
    end
  end

  assign cfg_chan.ready = 1'b1;

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3;
  logic [WORD_W-1:0]  p2w, p3w, p4w, p5w, p6w, p7w, p8w, p9w, p1w;

  assign t1  = cal_r[REG_T1_T2][15:0];
  assign t2  = cal_r[REG_T1_T2][31:16];
  assign t3  = cal_r[REG_T3_P1][15:0];
  assign p1  = cal_r[REG_T3_P1][31:16];
  assign p1w = {48'd0, p1};
  assign p2w = {{48{cal_r[REG_P2_P3][15]}}, cal_r[REG_P2_P3][15:0]};
  assign p3w = {{48{cal_r[REG_P2_P3][31]}}, cal_r[REG_P2_P3][31:16]};
  assign p4w = {{48{cal_r[REG_P4_P5][15]}}, cal_r[REG_P4_P5][15:0]};
  assign p5w = {{48{cal_r[REG_P4_P5][31]}}, cal_r[REG_P4_P5][31:16]};
  assign p6w = {{48{cal_r[REG_P6_P7][15]}}, cal_r[REG_P6_P7][15:0]};
  assign p7w = {{48{cal_r[REG_P6_P7][31]}}, cal_r[REG_P6_P7][31:16]};
  assign p8w = {{48{cal_r[REG_P8_P9][15]}}, cal_r[REG_P8_P9][15:0]};
  assign p9w = {{48{cal_r[REG_P8_P9][31]}}, cal_r[REG_P8_P9][31:16]};

  // pipeline control
  logic           pipe_en;
  logic [LAT-1:0] vld_r;

  assign pipe_en       = !vld_r[LAT-1] || out_chan.ready;
  assign in_chan.ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[LAT-2:0], in_chan.valid};
    end
  end

  // temperature stages
  logic signed [18:0] a_nxt, a1_r;
  logic signed [16:0] d_nxt, d1_r;
  logic [RAW_W-1:0]   rp1_r, rp2_r, rp3_r, rp4_r, rp5_r;
  logic signed [34:0] m1_r, m1_sh;
  logic signed [33:0] dd_full;
  logic [31:0]        dd2_r;
  logic signed [20:0] e_s;
  logic signed [36:0] m3_r, m3_sh;
  logic [23:0]        v1t3_r;
  logic [22:0]        v2t;
  logic [24:0]        tsum;
  logic [OUT_W-1:0]   tf4_r, tf5_r, tc5_r;
  logic [34:0]        tfe, t5x;
  logic signed [34:0] tc_sh;
  logic [WORD_W-1:0]  v1p5_r;

  assign a_nxt = $signed({2'b00, in_chan.raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
  assign d_nxt = $signed({1'b0, in_chan.raw_temperature[19:4]}) - $signed({1'b0, t1});
  assign dd_full = d1_r * d1_r;
  assign m1_sh = m1_r >>> 11;
  assign e_s   = $signed({1'b0, dd2_r[31:12]});
  assign m3_sh = m3_r >>> 14;
  assign v2t   = m3_sh[22:0];
  assign tsum  = {v1t3_r[23], v1t3_r} + {{2{v2t[22]}}, v2t};
  assign tfe   = {{3{tf4_r[31]}}, tf4_r};
  assign t5x   = {tfe[32:0], 2'b00} + tfe + 35'd128;
  assign tc_sh = $signed(t5x) >>> 8;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a1_r   <= a_nxt;
      d1_r   <= d_nxt;
      rp1_r  <= in_chan.raw_pressure;
      m1_r   <= a1_r * t2;
      dd2_r  <= dd_full[31:0];
      rp2_r  <= rp1_r;
      v1t3_r <= m1_sh[23:0];
      m3_r   <= e_s * t3;
      rp3_r  <= rp2_r;
      tf4_r  <= {{7{tsum[24]}}, tsum};
      rp4_r  <= rp3_r;
      tf5_r  <= tf4_r;
      tc5_r  <= tc_sh[31:0];
      v1p5_r <= {{32{tf4_r[31]}}, tf4_r} - 64'd128000;
      rp5_r  <= rp4_r;
    end
  end

  // pressure front end
  logic [WORD_W-1:0] sq7, mp5_7, mp2_7, x6_9, x3_9;
  logic [WORD_W-1:0] mp5_d_r [MUL_LAT];
  logic [WORD_W-1:0] mp2_d_r [MUL_LAT];
  logic [RAW_W-1:0]  rp_d_r  [RP_DLY];
  logic [WORD_W-1:0] v2_10_r, v1a_10_r, v1a_sh;

  ptc_mul64 u_mul_sq  (.clk(clk), .en(pipe_en), .a(v1p5_r), .b(v1p5_r), .p(sq7));
  ptc_mul64 u_mul_p5  (.clk(clk), .en(pipe_en), .a(v1p5_r), .b(p5w), .p(mp5_7));
  ptc_mul64 u_mul_p2  (.clk(clk), .en(pipe_en), .a(v1p5_r), .b(p2w), .p(mp2_7));
  ptc_mul64 u_mul_p6  (.clk(clk), .en(pipe_en), .a(sq7), .b(p6w), .p(x6_9));
  ptc_mul64 u_mul_p3  (.clk(clk), .en(pipe_en), .a(sq7), .b(p3w), .p(x3_9));

  assign v1a_sh = $signed(x3_9) >>> 8;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mp5_d_r[0] <= mp5_7;
      mp2_d_r[0] <= mp2_7;
      for (int i = 1; i < MUL_LAT; i++) begin
        mp5_d_r[i] <= mp5_d_r[i-1];
        mp2_d_r[i] <= mp2_d_r[i-1];
      end
      rp_d_r[0] <= rp5_r;
      for (int i = 1; i < RP_DLY; i++) rp_d_r[i] <= rp_d_r[i-1];
      v2_10_r  <= x6_9 + (mp5_d_r[MUL_LAT-1] << 17) + (p4w << 35);
      v1a_10_r <= v1a_sh + (mp2_d_r[MUL_LAT-1] << 12);
    end
  end

  // denominator and numerator
  logic [20:0]       pr_s;
  logic [WORD_W-1:0] num0, prc_12, num_12, den_sh;
  logic [WORD_W-1:0] den13_r, num13_r;
  logic              inv13_r;

  assign pr_s = 21'd1048576 - {1'b0, rp_d_r[RP_DLY-1]};
  assign num0 = ({43'd0, pr_s} << 31) - v2_10_r;

  ptc_mul64 u_mul_p1 (.clk(clk), .en(pipe_en), .a(v1a_10_r + (64'd1 << 47)), .b(p1w),
                      .p(prc_12));
  ptc_mul64 u_mul_k  (.clk(clk), .en(pipe_en), .a(num0), .b(64'd3125), .p(num_12));

  assign den_sh = $signed(prc_12) >>> 33;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      den13_r <= den_sh;
      num13_r <= num_12;
      inv13_r <= (den_sh == '0);
    end
  end

  // division and back end
  logic [WORD_W-1:0] q79, a_sh, aa81, p8q81, aa9_83, fsum, fsh, pf;
  logic [WORD_W-1:0] q_d_r   [Q_DLY];
  logic [WORD_W-1:0] p8q_d_r [MUL_LAT];
  logic              inv_d_r [INV_DLY];
  temp_res_t         tmp_d_r [TMP_DLY];
  logic [OUT_W-1:0]  pf_r;

  ptc_div u_div (.clk(clk), .en(pipe_en), .num(num13_r), .den(den13_r), .quo(q79));

  assign a_sh = $signed(q79) >>> 13;

  ptc_mul64 u_mul_aa (.clk(clk), .en(pipe_en), .a(a_sh), .b(a_sh), .p(aa81));
  ptc_mul64 u_mul_p8 (.clk(clk), .en(pipe_en), .a(q79), .b(p8w), .p(p8q81));
  ptc_mul64 u_mul_p9 (.clk(clk), .en(pipe_en), .a(aa81), .b(p9w), .p(aa9_83));

  assign fsum = q_d_r[Q_DLY-1] + 64'($signed(aa9_83) >>> 25)
              + 64'($signed(p8q_d_r[MUL_LAT-1]) >>> 19);
  assign fsh  = $signed(fsum) >>> 8;
  assign pf   = fsh + (p7w << 4);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      q_d_r[0] <= q79;
      for (int i = 1; i < Q_DLY; i++) q_d_r[i] <= q_d_r[i-1];
      p8q_d_r[0] <= p8q81;
      for (int i = 1; i < MUL_LAT; i++) p8q_d_r[i] <= p8q_d_r[i-1];
      inv_d_r[0] <= inv13_r;
      for (int i = 1; i < INV_DLY; i++) inv_d_r[i] <= inv_d_r[i-1];
      tmp_d_r[0] <= '{fine: tf5_r, centi: tc5_r};
      for (int i = 1; i < TMP_DLY; i++) tmp_d_r[i] <= tmp_d_r[i-1];
      pf_r <= pf[OUT_W-1:0];
    end
  end

  assign out_chan.valid             = vld_r[LAT-1];
  assign out_chan.fine_temperature  = tmp_d_r[TMP_DLY-1].fine;
  assign out_chan.temperature_centi = tmp_d_r[TMP_DLY-1].centi;
  assign out_chan.pressure_invalid  = inv_d_r[INV_DLY-1];
  assign out_chan.pressure_q24_8    = inv_d_r[INV_DLY-1] ? '0 : pf_r;

endmodule

### hdl/ptc_checker.sv
// Port-level checker for the compensation core, bound to the top level.
`include "pressure_temperature_compensation_core_macros.svh"

module ptc_checker import ptc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_fine,
  input logic [OUT_W-1:0] out_centi,
  input logic [OUT_W-1:0] out_pressure,
  input logic             out_invalid,
  input logic             cfg_ready
);

  `PTC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")
  `PTC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_fine) && $stable(out_centi) && $stable(out_pressure) && $stable(out_invalid), "stalled result changed")
  `PTC_ASSERT(a_backpressure, in_ready == (!out_valid || out_ready) && cfg_ready, "input ready does not follow output stall")
  `PTC_ASSERT(a_invalid_zero, out_valid && out_invalid |-> out_pressure == '0, "invalid pressure not zero")

endmodule

bind pressure_temperature_compensation_core ptc_checker u_ptc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_fine     (out_chan.fine_temperature),
  .out_centi    (out_chan.temperature_centi),
  .out_pressure (out_chan.pressure_q24_8),
  .out_invalid  (out_chan.pressure_invalid),
  .cfg_ready    (cfg_chan.ready)
);
